// ----- sv/cmp_pkg.sv -----
package cmp_pkg;

  // Sample format: signed Q3.12
  localparam int DATA_W    = 16;
  localparam int FRAC_BITS = 12;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = 40;
  localparam int POOL_W    = DATA_W - 1;

  // Request kinds on the input channel
  localparam logic REQ_COEF  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef logic signed [DATA_W-1:0] pix_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  csum_t;
  typedef logic [POOL_W-1:0]        pval_t;

  localparam csum_t ROUND_HALF = csum_t'(1) <<< (FRAC_BITS - 1);
  localparam csum_t SAT_MAX    = csum_t'((1 << POOL_W) - 1);

  function automatic pval_t pmax(input pval_t a, input pval_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- sv/conv5x5_maxpool3x3_stride2.sv -----
// Streaming KxK convolution (one filter) followed by 3x3 stride-2 max pooling with
// zero padding and a zero floor (ReLU). Coefficient items (req_type 0) load the
// weights and the bias (index K*K); pixel items (req_type 1) arrive in raster order,
// IMG_SIZE x IMG_SIZE per frame. One item is taken every clock cycle unless the
// pipeline stalls; a pooled result reaches the output register once the pixel
// completing its window has passed the column cells, the summing, rounding and
// pooling stages. The window is a row of K column cells fed by a single line memory
// holding the previous K-1 rows, one column per entry. The whole pipeline stalls
// only while the output register holds a result that is not taken. Weights persist
// across frames; the pixel position wraps to the frame origin after the last pixel.
module conv5x5_maxpool3x3_stride2 #(
  parameter int IMG_SIZE    = 48,
  parameter int KERNEL_SIZE = 5,
  localparam int K     = KERNEL_SIZE,
  localparam int NCOEF = K * K,
  localparam int IW    = $clog2(NCOEF + 1),
  localparam int CONV  = IMG_SIZE - K + 1,
  localparam int POOL  = (CONV - 1) / 2 + 1,
  localparam int PW    = $clog2(POOL),
  localparam int CW    = $clog2(IMG_SIZE)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [IW-1:0]         coef_index,
  input  logic signed [15:0]    value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [14:0]           pooled,
  output logic [PW-1:0]         out_row,
  output logic [PW-1:0]         out_col,
  output logic                  last
);
  import cmp_pkg::*;

  localparam int LBW = (K - 1) * DATA_W;

  logic en;
  logic acc_in;

  // Raster position of the next pixel
  logic [CW-1:0] pix_row, pix_col;

  // Stage 1: accepted item
  logic          s1_v;
  logic          s1_pix;
  logic [IW-1:0] s1_idx;
  pix_t          s1_val;
  logic          s1_wv;
  logic [CW-1:0] s1_cr, s1_cc;

  logic [LBW-1:0] lb_rd;
  logic [LBW-1:0] lb_wd;

  // Window tags, stages 2..6
  logic          tv  [2:6];
  logic [CW-1:0] tcr [2:6];
  logic [CW-1:0] tcc [2:6];

  pix_t  weights [NCOEF+1];
  pix_t  bias3, bias4;
  csum_t acc5;
  pval_t v6;

  pix_t  newcol [K];
  pix_t  wcol   [K][K];
  pix_t  wsel   [K][K];
  csum_t csums  [K];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign acc_in   = in_valid && en;

  // Advance pixel position on each accepted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_row <= '0;
      pix_col <= '0;
    end else if (acc_in && req_type == REQ_PIXEL) begin
      if (pix_col == CW'(IMG_SIZE - 1)) begin
        pix_col <= '0;
        pix_row <= (pix_row == CW'(IMG_SIZE - 1)) ? '0 : pix_row + 1'b1;
      end else begin
        pix_col <= pix_col + 1'b1;
      end
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      s1_pix <= req_type;
      s1_idx <= coef_index;
      s1_val <= value;
      s1_wv  <= (pix_row >= CW'(K - 1)) && (pix_col >= CW'(K - 1));
      s1_cr  <= pix_row - CW'(K - 1);
      s1_cc  <= pix_col - CW'(K - 1);
    end
  end

  // Line memory: entry per column, previous K-1 rows newest first
  assign lb_wd = {lb_rd[LBW-DATA_W-1:0], s1_val};

  cmp_line_buf #(
    .DEPTH(IMG_SIZE),
    .WIDTH(LBW),
    .AW   (CW)
  ) u_line_buf (
    .clk  (clk),
    .en   (en),
    .we   (en && s1_v && s1_pix),
    .waddr(s1_cc + CW'(K - 1)),
    .wdata(lb_wd),
    .raddr(pix_col),
    .rdata(lb_rd)
  );

  // Coefficient writes land one stage after accept, in item order
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NCOEF; i++) begin
        weights[i] <= '0;
      end
    end else if (en && s1_v && !s1_pix && s1_idx <= IW'(NCOEF)) begin
      weights[s1_idx] <= s1_val;
    end
  end

  // Newest window column: oldest row at the top
  always_comb begin
    for (int i = 0; i < K - 1; i++) begin
      newcol[i] = lb_rd[(K - 2 - i) * DATA_W +: DATA_W];
    end
    newcol[K-1] = s1_val;
  end

  // Row of column cells, each handing its column to the left neighbor
  for (genvar j = 0; j < K; j++) begin : g_cell
    for (genvar i = 0; i < K; i++) begin : g_wt
      assign wsel[j][i] = weights[i * K + j];
    end
    if (j == K - 1) begin : g_head
      cmp_col_cell #(.K(K)) u_cell (
        .clk    (clk),
        .en     (en),
        .shift  (s1_v && s1_pix),
        .col_in (newcol),
        .wt     (wsel[j]),
        .col_out(wcol[j]),
        .csum   (csums[j])
      );
    end else begin : g_body
      cmp_col_cell #(.K(K)) u_cell (
        .clk    (clk),
        .en     (en),
        .shift  (s1_v && s1_pix),
        .col_in (wcol[j+1]),
        .wt     (wsel[j]),
        .col_out(wcol[j]),
        .csum   (csums[j])
      );
    end
  end

  // Tag pipeline alongside the cells
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 2; k <= 6; k++) begin
        tv[k] <= 1'b0;
      end
    end else if (en) begin
      tv[2] <= s1_v && s1_pix && s1_wv;
      for (int k = 3; k <= 6; k++) begin
        tv[k] <= tv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tcr[2] <= s1_cr;
      tcc[2] <= s1_cc;
      for (int k = 3; k <= 6; k++) begin
        tcr[k] <= tcr[k-1];
        tcc[k] <= tcc[k-1];
      end
    end
  end

  // Bias follows the products; sum columns, round, saturate with zero floor
  always_ff @(posedge clk) begin
    csum_t s;
    csum_t t;
    csum_t q;
    if (en) begin
      bias3 <= weights[NCOEF];
      bias4 <= bias3;
      s = csum_t'(bias4) <<< FRAC_BITS;
      for (int j = 0; j < K; j++) begin
        s = s + csums[j];
      end
      acc5 <= s;
      t = acc5 + ROUND_HALF;
      q = t >>> FRAC_BITS;
      if (q < 0) begin
        v6 <= '0;
      end else if (q > SAT_MAX) begin
        v6 <= SAT_MAX[POOL_W-1:0];
      end else begin
        v6 <= q[POOL_W-1:0];
      end
    end
  end

  // Horizontal pooling over three conv columns
  pval_t         hcarry, hmax;
  logic          h7_v;
  pval_t         h7;
  logic [PW-1:0] h7_pc;
  logic [CW-1:0] h7_cr;
  pval_t         hin;
  logic          cdone;

  assign hin   = (tcc[6] == '0) ? '0 : hcarry;
  assign cdone = tcc[6][0] || tcc[6] == CW'(CONV - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      h7_v <= 1'b0;
    end else if (en) begin
      h7_v <= tv[6] && cdone;
    end
  end

  always_ff @(posedge clk) begin
    if (en && tv[6]) begin
      h7_pc <= PW'(tcc[6] >> 1);
      h7_cr <= tcr[6];
      if (tcc[6][0]) begin
        h7     <= pmax(hmax, v6);
        hcarry <= v6;
      end else begin
        hmax <= pmax(hin, v6);
        h7   <= pmax(hin, v6);
      end
    end
  end

  // Vertical pooling: one running row of partial maxima
  pval_t prow [POOL];
  pval_t cur, vnew;
  logic  rdone;

  assign cur   = prow[h7_pc];
  assign rdone = h7_cr[0] || h7_cr == CW'(CONV - 1);

  always_comb begin
    if (h7_cr[0]) begin
      vnew = h7;
    end else if (h7_cr == '0) begin
      vnew = h7;
    end else begin
      vnew = pmax(cur, h7);
    end
  end

  always_ff @(posedge clk) begin
    if (en && h7_v) begin
      prow[h7_pc] <= vnew;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= h7_v && rdone;
    end
  end

  always_ff @(posedge clk) begin
    if (en && h7_v && rdone) begin
      pooled  <= h7_cr[0] ? pmax(cur, h7) : vnew;
      out_row <= PW'(h7_cr >> 1);
      out_col <= h7_pc;
      last    <= (PW'(h7_cr >> 1) == PW'(POOL - 1)) && (h7_pc == PW'(POOL - 1));
    end
  end

endmodule

// ----- sv/cmp_line_buf.sv -----
module cmp_line_buf #(
  parameter int DEPTH = 48,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle; the read register holds while en is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/cmp_col_cell.sv -----
module cmp_col_cell #(
  parameter int K = 5
) (
  input  logic          clk,
  input  logic          en,
  input  logic          shift,
  input  cmp_pkg::pix_t col_in [K],
  input  cmp_pkg::pix_t wt [K],
  output cmp_pkg::pix_t col_out [K],
  output cmp_pkg::csum_t csum
);
  import cmp_pkg::*;

  pix_t  col  [K];
  prod_t prod [K];
  csum_t sum_c;

  // Hold one window column, multiply it by its weights, then add the column up
  always_ff @(posedge clk) begin
    if (en) begin
      if (shift) begin
        col <= col_in;
      end
      for (int i = 0; i < K; i++) begin
        prod[i] <= prod_t'(col[i]) * prod_t'(wt[i]);
      end
      csum <= sum_c;
    end
  end

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < K; i++) begin
      sum_c = sum_c + csum_t'(prod[i]);
    end
  end

  assign col_out = col;

endmodule

// ----- test/tb_conv5x5_maxpool3x3_stride2.sv -----
module tb_conv5x5_maxpool3x3_stride2;
  import cmp_pkg::*;

  localparam int IMG   = 48;
  localparam int KS    = 5;
  localparam int NCF   = KS * KS;
  localparam int CSZ   = IMG - KS + 1;
  localparam int PSZ   = (CSZ - 1) / 2 + 1;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [14:0] pooled;
    logic [4:0]  row;
    logic [4:0]  col;
    logic        last;
  } pool_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = REQ_COEF;
  logic [4:0]  coef_index = '0;
  logic signed [15:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [14:0] pooled;
  logic [4:0]  out_row;
  logic [4:0]  out_col;
  logic        last;

  conv5x5_maxpool3x3_stride2 uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .coef_index(coef_index), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .pooled(pooled), .out_row(out_row), .out_col(out_col), .last(last)
  );

  // Predictor state
  logic signed [15:0] img_lines [KS][IMG];
  int                 coefs [NCF+1];
  logic [15:0]        pool_cur [PSZ];
  logic [15:0]        pool_next [PSZ];
  int                 pix_r, pix_c;
  pool_res_t          pool_expect_q [$];

  int  fail_count = 0;
  int  idle_cycles = 0;
  logic long_hold_tog = 1'b0;
  int  burst_left = 0;
  bit  no_gaps = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Window whose bottom-right pixel is (r, c), clipped to 0..32767
  function automatic logic [15:0] conv_value(int r, int c);
    longint acc;
    longint q;
    acc = longint'(coefs[NCF]) * 4096;
    for (int i = 0; i < KS; i++)
      for (int j = 0; j < KS; j++)
        acc += longint'(coefs[i*KS+j]) * longint'(img_lines[(r-KS+1+i) % KS][c-KS+1+j]);
    q = (acc + 2048) >>> 12;
    if (q > 32767) q = 32767;
    if (q < 0) q = 0;
    return q[15:0];
  endfunction

  task automatic pool_merge(ref logic [15:0] rowbuf [PSZ], input int pc, input bit odd_c,
                            input logic [15:0] v);
    if (pc < PSZ && rowbuf[pc] < v) rowbuf[pc] = v;
    if (odd_c && pc + 1 < PSZ && rowbuf[pc+1] < v) rowbuf[pc+1] = v;
  endtask

  task automatic predict_item(logic rt, logic [4:0] idx, logic signed [15:0] val);
    int cr, cc, pr, pc;
    bit odd_r, odd_c, row_done, col_done;
    logic [15:0] v;
    pool_res_t res;
    if (rt == REQ_COEF) begin
      if (idx <= NCF) coefs[idx] = val;
      return;
    end
    img_lines[pix_r % KS][pix_c] = val;
    if (pix_r >= KS - 1 && pix_c >= KS - 1) begin
      cr = pix_r - (KS - 1);
      cc = pix_c - (KS - 1);
      pr = cr >> 1;
      pc = cc >> 1;
      odd_r = cr[0];
      odd_c = cc[0];
      row_done = odd_r || cr == CSZ - 1;
      col_done = odd_c || cc == CSZ - 1;
      v = conv_value(pix_r, pix_c);
      pool_merge(pool_cur, pc, odd_c, v);
      if (odd_r && pr + 1 < PSZ) pool_merge(pool_next, pc, odd_c, v);
      if (row_done && col_done && pc < PSZ) begin
        res.pooled = pool_cur[pc][14:0];
        res.row = pr[4:0];
        res.col = pc[4:0];
        res.last = (pr == PSZ - 1 && pc == PSZ - 1);
        pool_expect_q.push_back(res);
      end
      if (row_done && cc == CSZ - 1) begin
        pool_cur = pool_next;
        foreach (pool_next[k]) pool_next[k] = '0;
      end
    end
    pix_c++;
    if (pix_c >= IMG) begin
      pix_c = 0;
      pix_r++;
      if (pix_r >= IMG) begin
        pix_r = 0;
        foreach (pool_cur[k]) begin
          pool_cur[k] = '0;
          pool_next[k] = '0;
        end
      end
    end
  endtask

  // Offer one item, hold it until taken, then maybe idle between bursts
  task automatic send_item(logic rt, logic [4:0] idx, logic signed [15:0] val);
    bit taken;
    int gap;
    in_valid <= 1'b1;
    req_type <= rt;
    coef_index <= idx;
    value <= val;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    predict_item(rt, idx, val);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!no_gaps) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic signed [15:0] pick_value(int mode);
    case (mode)
      0: return $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
      1: return 16'($urandom);
      default: begin
        case ($urandom_range(0, 2))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          default: return 16'sh0000;
        endcase
      end
    endcase
  endfunction

  task automatic load_coefs(int mode);
    for (int i = 0; i <= NCF; i++) send_item(REQ_COEF, i[4:0], pick_value(mode));
  endtask

  // Stretch of pixels; occasional coefficient writes land mid-frame, some out of range
  task automatic run_frame(int mode, int npix);
    for (int n = 0; n < npix; n++) begin
      if ($urandom_range(0, 199) == 0)
        send_item(REQ_COEF, 5'($urandom_range(0, 31)), pick_value(mode));
      send_item(REQ_PIXEL, 5'($urandom), pick_value(mode));
    end
  endtask

  task automatic test_coef_extremes();
    send_item(REQ_COEF, 5'd0, 16'sh7fff);
    send_item(REQ_COEF, 5'd24, 16'sh8000);
    send_item(REQ_COEF, 5'd25, 16'sh7fff);
    send_item(REQ_COEF, 5'd26, 16'sh8000);
    send_item(REQ_COEF, 5'd31, 16'sh8000);
    send_item(REQ_COEF, 5'd12, 16'sh1000);
    send_item(REQ_COEF, 5'd25, 16'sh0000);
  endtask

  task automatic test_extreme_frame();
    load_coefs(2);
    run_frame(2, 400);
  endtask

  task automatic test_random_frames();
    no_gaps = 1;
    load_coefs(0);
    run_frame(0, 600);
    no_gaps = 0;
    load_coefs(1);
    run_frame(1, 600);
  endtask

  // Runs past the end of the frame while the receiver holds off
  task automatic test_backpressure();
    long_hold_tog = ~long_hold_tog;
    no_gaps = 1;
    load_coefs(0);
    for (int n = 0; n < 720; n++) send_item(REQ_PIXEL, 5'd0, pick_value(0));
    no_gaps = 0;
  endtask

  // Receiver: stall pattern re-picked at random from four modes; long hold on request
  int  rcv_cycle = 0;
  int  rcv_mode = 0;
  int  hold_left = 0;
  logic hold_seen = 1'b0;
  always @(posedge clk) begin
    rcv_cycle <= rcv_cycle + 1;
    if (rcv_cycle % 64 == 0) rcv_mode <= $urandom_range(0, 3);
    if (hold_seen != long_hold_tog) begin
      hold_seen <= long_hold_tog;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (rcv_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= rcv_cycle[2];
      endcase
    end
  end

  // Check each result taken at the coming edge; watch for a stuck handshake
  always @(negedge clk) begin
    pool_res_t exp_res;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pool_expect_q.size() == 0) begin
          $display("%0t: unexpected result pooled=%0d row=%0d col=%0d last=%0d",
                   $time, pooled, out_row, out_col, last);
          fail_count++;
        end else begin
          exp_res = pool_expect_q.pop_front();
          if (exp_res.pooled !== pooled) begin
            $display("%0t: pooled expected %0d actual %0d", $time, exp_res.pooled, pooled);
            fail_count++;
          end
          if (exp_res.row !== out_row) begin
            $display("%0t: out_row expected %0d actual %0d", $time, exp_res.row, out_row);
            fail_count++;
          end
          if (exp_res.col !== out_col) begin
            $display("%0t: out_col expected %0d actual %0d", $time, exp_res.col, out_col);
            fail_count++;
          end
          if (exp_res.last !== last) begin
            $display("%0t: last expected %0d actual %0d", $time, exp_res.last, last);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    foreach (img_lines[i, j]) img_lines[i][j] = '0;
    foreach (coefs[i]) coefs[i] = 0;
    foreach (pool_cur[i]) begin
      pool_cur[i] = '0;
      pool_next[i] = '0;
    end
    pix_r = 0;
    pix_c = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_coef_extremes();
    test_extreme_frame();
    test_random_frames();
    test_backpressure();
    in_valid <= 1'b0;
    while (pool_expect_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pool_expect_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
